### rtl/core/ssag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_pkg: shared types and constants
// Register codes, controller states and the command/status bundles that pass
// between the strided slice controller and its datapath.
// ----------------------------------------------------------------------------
package ssag_pkg;

	localparam int FIELD_W   = 16;  // packing pitch of one axis field
	localparam int REG_W     = 64;  // widest configuration register
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W     = 32;  // element index / byte offset width
	localparam int EB_W      = 5;   // element_bytes width
	localparam int AXES_W    = 3;   // axes_used width

	localparam logic [AXES_W-1:0] AXES_RESET  = 3'd1;
	localparam logic [REG_W-1:0]  START_RESET = 64'h0;
	localparam logic [REG_W-1:0]  STOP_RESET  = 64'h0;
	localparam logic [REG_W-1:0]  SKIP_RESET  = 64'h0001_0001_0001_0001;
	localparam logic [REG_W-1:0]  SHAPE_RESET = 64'h0001_0001_0001_0001;
	localparam logic [EB_W-1:0]   EB_RESET    = 5'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AXES_USED,
		CFG_START,
		CFG_STOP,
		CFG_SKIP,
		CFG_SHAPE,
		CFG_ELEM_BYTES
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_STRIDE,
		ST_POS,
		ST_ACC,
		ST_EMIT,
		ST_INC
	} ssag_state_t;

	typedef struct packed {
		logic walk_init;    // word accepted: clear accumulator, axis pointer
		logic restart;      // word carries restart
		logic div_start;    // launch count division for current axis
		logic count_wr;     // store count of current axis
		logic stride_step;  // stride[d-1] = stride[d] * shape[d]
		logic stride_end;   // setup finished
		logic pos_calc;     // pos = counter*skip + start
		logic acc_calc;     // acc += pos*stride
		logic emit;         // load output register
		logic inc_step;     // one step of the odometer carry
	} ssag_cmd_t;

	typedef struct packed {
		logic axis_first;
		logic axis_last;
		logic axis_nonempty;
		logic div_done;
		logic empty;
		logic walk_done;
		logic fin;
		logic inc_stop;
		logic out_free;
	} ssag_status_t;

endpackage
`default_nettype wire

### rtl/core/ssag_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_if: stream channels of the slice address generator
// Input channel carries the restart flag; output channel carries one
// element's addresses.
// ----------------------------------------------------------------------------
interface ssag_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface ssag_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_index;
	logic [31:0] dst_index;
	logic [31:0] src_byte_offset;
	logic [31:0] dst_byte_offset;
	logic        last;
	logic        done_res;

	modport source (output valid, output src_index, output dst_index,
		output src_byte_offset, output dst_byte_offset, output last,
		output done_res, input ready);
	modport sink   (input valid, input src_index, input dst_index,
		input src_byte_offset, input dst_byte_offset, input last,
		input done_res, output ready);
endinterface
`default_nettype wire

### rtl/core/ssag_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_div: radix-2 restoring divider
// Unsigned quotient of two W-bit values, one quotient bit per cycle.
// done pulses as the last bit is registered into quo; quo holds until the next start.
// ----------------------------------------------------------------------------
module ssag_div #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic [W-1:0]      quo
);
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [W:0]       shifted;
	logic             take;

	assign shifted = {rem_q, quo_q[W-1]};
	assign take    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? W'(shifted - {1'b0, den_q}) : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

### rtl/core/ssag_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_ctrl: sequencer of the slice address generator
// Steps setup (count division, stride chain) and the per-word walk
// (per-axis position and accumulate, emit, odometer carry).
// ----------------------------------------------------------------------------
module ssag_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_restart,
	output logic                        in_ready,
	input  wire ssag_pkg::ssag_status_t st,
	output ssag_pkg::ssag_cmd_t         cmd
);
	import ssag_pkg::*;

	ssag_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_restart) state_d = ST_DIV_START;
					else state_d = st.walk_done ? ST_EMIT : ST_POS;
				end
			end
			ST_DIV_START: begin
				if (st.axis_nonempty) state_d = ST_DIV_WAIT;
				else state_d = st.axis_last ? ST_STRIDE : ST_DIV_START;
			end
			ST_DIV_WAIT: begin
				if (st.div_done) state_d = st.axis_last ? ST_STRIDE : ST_DIV_START;
			end
			ST_STRIDE: begin
				if (st.axis_first) state_d = st.empty ? ST_EMIT : ST_POS;
			end
			ST_POS: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = st.axis_last ? ST_EMIT : ST_POS;
			end
			ST_EMIT: begin
				if (st.out_free) state_d = (st.walk_done || st.fin) ? ST_IDLE : ST_INC;
			end
			ST_INC: begin
				if (st.inc_stop) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.walk_init = in_valid;
				cmd.restart   = in_valid && in_restart;
			end
			ST_DIV_START: begin
				cmd.div_start = st.axis_nonempty;
				cmd.count_wr  = !st.axis_nonempty;
			end
			ST_DIV_WAIT: begin
				cmd.count_wr = st.div_done;
			end
			ST_STRIDE: begin
				cmd.stride_end  = st.axis_first;
				cmd.stride_step = !st.axis_first;
			end
			ST_POS: begin
				cmd.pos_calc = 1'b1;
			end
			ST_ACC: begin
				cmd.acc_calc = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = st.out_free;
			end
			ST_INC: begin
				cmd.inc_step = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/ssag_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssag_dp: datapath of the slice address generator
// Configuration registers, per-axis counters, counts and strides, the
// shared position/accumulate arithmetic and the output register.
// ----------------------------------------------------------------------------
module ssag_dp #(
	parameter int MAX_AXES   = 4,
	parameter int COORD_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ssag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ssag_pkg::REG_W-1:0]      cfg_data,
	input  wire ssag_pkg::ssag_cmd_t             cmd,
	output ssag_pkg::ssag_status_t               st,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [ssag_pkg::IDX_W-1:0]           out_src_index,
	output logic [ssag_pkg::IDX_W-1:0]           out_dst_index,
	output logic [ssag_pkg::IDX_W-1:0]           out_src_byte_offset,
	output logic [ssag_pkg::IDX_W-1:0]           out_dst_byte_offset,
	output logic                                 out_last,
	output logic                                 out_done_res
);
	import ssag_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

	// configuration
	logic [AXES_W-1:0] axes_used_q;
	logic [REG_W-1:0]  start_q, stop_q, skip_q, shape_q;
	logic [EB_W-1:0]   eb_q;

	// walk state
	logic [CB-1:0]    counter_q [MAX_AXES];
	logic [CB-1:0]    count_q   [MAX_AXES];
	logic [IDX_W-1:0] stride_q  [MAX_AXES];
	logic [IDX_W-1:0] dest_q;
	logic             walk_done_q;
	logic             empty_q;
	logic [AXW-1:0]   nm1_q;
	logic [AXW-1:0]   d_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] acc_q;
	logic             fin_q;
	logic             out_valid_q;

	// current-axis fields
	logic [CB-1:0]        start_f, stop_f, skip_f, shape_f, skip_v, cur_cnt, cur_count;
	logic [CB:0]          cnt_plus;
	logic [AXW-1:0]       dm1;
	logic [AXW-1:0]       nm1_d;
	logic [2*CB-1:0]      cnt_skip;
	logic [IDX_W-1:0]     pos_d;
	logic [2*IDX_W-1:0]   pos_str;
	logic [IDX_W+CB-1:0]  str_shape;
	logic [IDX_W+EB_W-1:0] src_b, dst_b;
	logic                 div_done;
	logic [CB-1:0]        div_quo;

	assign start_f = start_q[FIELD_W*d_q +: CB];
	assign stop_f  = stop_q[FIELD_W*d_q +: CB];
	assign skip_f  = skip_q[FIELD_W*d_q +: CB];
	assign shape_f = shape_q[FIELD_W*d_q +: CB];
	assign skip_v  = (skip_f == '0) ? CB'(1) : skip_f;

	assign cur_cnt   = counter_q[d_q];
	assign cur_count = count_q[d_q];
	assign cnt_plus  = {1'b0, cur_cnt} + (CB+1)'(1);
	assign dm1       = d_q - AXW'(1);

	assign cnt_skip  = cur_cnt * skip_v;
	assign pos_d     = IDX_W'(cnt_skip) + IDX_W'(start_f);
	assign pos_str   = pos_q * stride_q[d_q];
	assign str_shape = stride_q[d_q] * shape_f;
	assign src_b     = acc_q * eb_q;
	assign dst_b     = dest_q * eb_q;

	always_comb begin
		if (axes_used_q == '0) nm1_d = '0;
		else if (axes_used_q > AXES_W'(MAX_AXES)) nm1_d = AXW'(MAX_AXES - 1);
		else nm1_d = AXW'(axes_used_q - AXES_W'(1));
	end

	ssag_div #(
		.W(CB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (stop_f - start_f - CB'(1)),
		.den    (skip_v),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		st.axis_first    = d_q == '0;
		st.axis_last     = d_q == nm1_q;
		st.axis_nonempty = stop_f > start_f;
		st.div_done      = div_done;
		st.empty         = empty_q;
		st.walk_done     = walk_done_q;
		st.fin           = fin_q;
		st.inc_stop      = (cnt_plus < {1'b0, cur_count}) || (d_q == '0);
		st.out_free      = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_used_q <= AXES_RESET;
			start_q     <= START_RESET;
			stop_q      <= STOP_RESET;
			skip_q      <= SKIP_RESET;
			shape_q     <= SHAPE_RESET;
			eb_q        <= EB_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_AXES_USED:  axes_used_q <= cfg_data[AXES_W-1:0];
				CFG_START:      start_q     <= cfg_data;
				CFG_STOP:       stop_q      <= cfg_data;
				CFG_SKIP:       skip_q      <= cfg_data;
				CFG_SHAPE:      shape_q     <= cfg_data;
				CFG_ELEM_BYTES: eb_q        <= cfg_data[EB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_AXES; i++) begin
				counter_q[i] <= '0;
				count_q[i]   <= '0;
				stride_q[i]  <= '0;
			end
			dest_q      <= '0;
			walk_done_q <= 1'b1;
			empty_q     <= 1'b0;
			nm1_q       <= '0;
			d_q         <= '0;
			fin_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.walk_init) begin
				d_q   <= '0;
				fin_q <= 1'b1;
			end
			if (cmd.restart) begin
				for (int i = 0; i < MAX_AXES; i++) counter_q[i] <= '0;
				nm1_q   <= nm1_d;
				dest_q  <= '0;
				empty_q <= 1'b0;
			end
			if (cmd.count_wr) begin
				count_q[d_q] <= st.axis_nonempty ? div_quo + CB'(1) : '0;
				if (!st.axis_nonempty) empty_q <= 1'b1;
				if (st.axis_last) stride_q[d_q] <= IDX_W'(1);
				else d_q <= d_q + AXW'(1);
			end
			if (cmd.stride_step) begin
				stride_q[dm1] <= str_shape[IDX_W-1:0];
				d_q           <= dm1;
			end
			if (cmd.stride_end) begin
				walk_done_q <= empty_q;
			end
			if (cmd.acc_calc) begin
				if (cnt_plus != {1'b0, cur_count}) fin_q <= 1'b0;
				if (!st.axis_last) d_q <= d_q + AXW'(1);
			end
			if (cmd.emit && !walk_done_q) begin
				dest_q <= dest_q + IDX_W'(1);
				d_q    <= nm1_q;
				if (fin_q) walk_done_q <= 1'b1;
			end
			if (cmd.inc_step) begin
				if (st.inc_stop) begin
					counter_q[d_q] <= cnt_plus[CB-1:0];
				end else begin
					counter_q[d_q] <= '0;
					d_q            <= dm1;
				end
			end
			// output word register
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) acc_q <= '0;
		else if (cmd.stride_end) acc_q <= '0;
		else if (cmd.acc_calc) acc_q <= acc_q + pos_str[IDX_W-1:0];
		if (cmd.pos_calc) pos_q <= pos_d;
		if (cmd.emit) begin
			if (walk_done_q) begin
				out_src_index       <= '0;
				out_dst_index       <= '0;
				out_src_byte_offset <= '0;
				out_dst_byte_offset <= '0;
				out_last            <= 1'b0;
				out_done_res        <= 1'b1;
			end else begin
				out_src_index       <= acc_q;
				out_dst_index       <= dest_q;
				out_src_byte_offset <= src_b[IDX_W-1:0];
				out_dst_byte_offset <= dst_b[IDX_W-1:0];
				out_last            <= fin_q;
				out_done_res        <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### rtl/core/strided_slice_address_gen.sv
`default_nettype none
// Sequencing: a walk word steps position and accumulate for each axis in use
//   in the shared per-axis loop, then emits, then runs the odometer carry.
// A restart word first runs the count divider for each nonempty axis
//   (one quotient bit per cycle) and then the stride chain.
// A finished word waits in the output register while the next is accepted.
// Reset: registers take their reset values, no walk active; no clear pass.
// ----------------------------------------------------------------------------
// strided_slice_address_gen: N-dimensional strided slice address generator
// One source/destination index and byte offset per word, innermost axis
// fastest, with a last flag; done words once the slice is exhausted.
// ----------------------------------------------------------------------------
module strided_slice_address_gen #(
	parameter int MAX_AXES   = 4,
	parameter int COORD_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ssag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ssag_pkg::REG_W-1:0]     cfg_data,
	ssag_in_if.sink                             in_ch,
	ssag_out_if.source                          out_ch
);
	import ssag_pkg::*;

	ssag_cmd_t    cmd;
	ssag_status_t st;

	ssag_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_restart (in_ch.restart),
		.in_ready   (in_ch.ready),
		.st         (st),
		.cmd        (cmd)
	);

	ssag_dp #(
		.MAX_AXES   (MAX_AXES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.cmd                 (cmd),
		.st                  (st),
		.out_valid           (out_ch.valid),
		.out_ready           (out_ch.ready),
		.out_src_index       (out_ch.src_index),
		.out_dst_index       (out_ch.dst_index),
		.out_src_byte_offset (out_ch.src_byte_offset),
		.out_dst_byte_offset (out_ch.dst_byte_offset),
		.out_last            (out_ch.last),
		.out_done_res        (out_ch.done_res)
	);

endmodule
`default_nettype wire
